// ----- rtl/mbrtu_pkg.sv -----
// Package for the Modbus RTU frame timing controller: item types, codes and constants.
package mbrtu_pkg;

  // Default largest frame in bytes.
  localparam int FRAME_MAX_DEF = 256;

  // Reset values of the configuration registers.
  localparam logic [15:0] FRAME_GAP_RST = 16'd75;
  localparam logic [15:0] CHAR_GAP_RST  = 16'd15;

  // Configuration register indexes.
  localparam logic REG_FRAME_GAP = 1'b0;
  localparam logic REG_CHAR_GAP  = 1'b1;

  // Controller states.
  typedef enum logic [2:0] {
    ST_INITIAL    = 3'd0,
    ST_READY      = 3'd1,
    ST_RECEPTION  = 3'd2,
    ST_PROCESSING = 3'd3,
    ST_EMISSION   = 3'd4
  } state_t;

  // Event kinds of an input item.
  typedef enum logic [1:0] {
    EV_CHAR   = 2'd0,
    EV_TICK   = 2'd1,
    EV_TXREQ  = 2'd2,
    EV_TXDONE = 2'd3
  } event_t;

  // Result kinds.
  typedef enum logic [1:0] {
    K_BYTE    = 2'd0,
    K_END     = 2'd1,
    K_TX      = 2'd2,
    K_RELEASE = 2'd3
  } kind_t;

  // Input item.
  typedef struct packed {
    logic [1:0] func;
    logic [7:0] rx_byte;
    logic [8:0] tx_length;
  } ev_item_t;

  // Result item.
  typedef struct packed {
    logic [1:0] out_kind;
    logic [7:0] out_byte;
    logic [8:0] out_count;
    logic       overflow;
    logic [2:0] fsm_now;
  } res_item_t;

endpackage

// ----- rtl/modbus_rtu_frame_timing_fsm_top.sv -----
// Modbus RTU frame timing controller: state machine, silence timer and byte count.
//
// Usage:
//   The ev channel carries one event per item: a received character, a timer
//   tick, a transmit request or a transmit-done. The res channel returns at most
//   one result per event: a frame byte with its index, a frame end with the
//   length, a transmit start, or a response release.
//   The state is updated in the cycle an item is accepted and its result, if
//   any, appears on res in the next cycle; an item can be accepted every cycle
//   while res is not stalled, so throughput is one item per cycle. Results pass
//   through the single result register between the state update and res.
//   Events that produce no result leave res untouched.
//   When res is stalled, ev_ready drops only while a result is held and not
//   being taken; the held result stays unchanged until taken.
//   Reset puts the controller in the initial wait with the silence timer at
//   the frame gap, clears the count and the overflow flag, and restores the
//   frame gap (75) and char gap (15) registers. The user must write registers
//   via cfg_we, cfg_index and cfg_wdata while the controller is idle (unenforced).
module modbus_rtu_frame_timing_fsm_top #(
  parameter int FRAME_MAX = mbrtu_pkg::FRAME_MAX_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 ev_valid,
  output logic                 ev_ready,
  input  mbrtu_pkg::ev_item_t  ev,
  output logic                 res_valid,
  input  logic                 res_ready,
  output mbrtu_pkg::res_item_t res,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [15:0]          cfg_wdata
);
  import mbrtu_pkg::*;

  localparam logic [8:0] FrameMax = 9'(FRAME_MAX);

  logic [15:0] frame_gap;
  logic [15:0] char_gap;
  state_t      state;
  state_t      state_next;
  logic [15:0] gap_timer;
  logic [15:0] gap_timer_next;
  logic [8:0]  byte_count;
  logic [8:0]  byte_count_next;
  logic        overflowed;
  logic        overflowed_next;
  logic        hit;
  kind_t       hit_kind;
  logic [7:0]  hit_byte;
  logic [8:0]  hit_count;
  logic        hit_ovf;
  logic        ev_fire;
  logic        expired;
  logic [15:0] proc_wait;

  assign ev_ready = !res_valid || res_ready;
  assign ev_fire  = ev_valid && ev_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_gap <= FRAME_GAP_RST;
      char_gap  <= CHAR_GAP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_GAP: frame_gap <= cfg_wdata;
        REG_CHAR_GAP:  char_gap  <= cfg_wdata;
        default:       frame_gap <= frame_gap;
      endcase
    end
  end

  // A tick expires the timer when one or zero ticks remain.
  assign expired   = (gap_timer <= 16'd1);
  // Processing wait is the frame gap less the char gap, floored at zero.
  assign proc_wait = (frame_gap > char_gap) ? (frame_gap - char_gap) : 16'd0;

  // Next state and result for the event on ev.
  always_comb begin
    state_next      = state;
    gap_timer_next  = gap_timer;
    byte_count_next = byte_count;
    overflowed_next = overflowed;
    hit             = 1'b0;
    hit_kind        = K_BYTE;
    hit_byte        = 8'd0;
    hit_count       = 9'd0;
    hit_ovf         = 1'b0;
    case (state)
      ST_READY: begin
        if (ev.func == EV_CHAR) begin
          state_next      = ST_RECEPTION;
          gap_timer_next  = frame_gap;
          overflowed_next = 1'b0;
          byte_count_next = 9'd1;
          hit             = 1'b1;
          hit_kind        = K_BYTE;
          hit_byte        = ev.rx_byte;
        end else if (ev.func == EV_TXREQ) begin
          if (ev.tx_length != 9'd0) begin
            state_next = ST_EMISSION;
            hit        = 1'b1;
            hit_kind   = K_TX;
            hit_count  = ev.tx_length;
          end
        end else if (ev.func == EV_TXDONE) begin
          state_next     = ST_INITIAL;
          gap_timer_next = frame_gap;
        end
      end
      ST_RECEPTION: begin
        if (ev.func == EV_CHAR) begin
          // Bytes beyond the frame limit are dropped but still reload the timer.
          if (byte_count < FrameMax) begin
            hit             = 1'b1;
            hit_kind        = K_BYTE;
            hit_byte        = ev.rx_byte;
            hit_count       = byte_count;
            byte_count_next = byte_count + 9'd1;
          end else begin
            overflowed_next = 1'b1;
          end
          gap_timer_next = frame_gap;
        end else if (ev.func == EV_TICK) begin
          if (expired) begin
            gap_timer_next = proc_wait;
            state_next     = ST_PROCESSING;
            hit            = 1'b1;
            hit_kind       = K_END;
            hit_count      = byte_count;
            hit_ovf        = overflowed;
          end else begin
            gap_timer_next = gap_timer - 16'd1;
          end
        end else begin
          state_next     = ST_INITIAL;
          gap_timer_next = frame_gap;
        end
      end
      ST_PROCESSING: begin
        if (ev.func == EV_TICK) begin
          if (expired) begin
            gap_timer_next = 16'd0;
            state_next     = ST_READY;
            hit            = 1'b1;
            hit_kind       = K_RELEASE;
            hit_count      = byte_count;
            hit_ovf        = overflowed;
          end else begin
            gap_timer_next = gap_timer - 16'd1;
          end
        end else begin
          state_next     = ST_INITIAL;
          gap_timer_next = frame_gap;
        end
      end
      ST_EMISSION: begin
        if (ev.func == EV_TXDONE) begin
          state_next     = ST_INITIAL;
          gap_timer_next = frame_gap;
        end
      end
      default: begin
        // Initial wait: any non-tick event restarts it.
        if (ev.func == EV_TICK) begin
          if (expired) begin
            gap_timer_next = 16'd0;
            state_next     = ST_READY;
          end else begin
            gap_timer_next = gap_timer - 16'd1;
            state_next     = ST_INITIAL;
          end
        end else begin
          state_next     = ST_INITIAL;
          gap_timer_next = frame_gap;
        end
      end
    endcase
  end

  // State register; it advances only on an accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_INITIAL;
      gap_timer  <= FRAME_GAP_RST;
      byte_count <= 9'd0;
      overflowed <= 1'b0;
    end else if (ev_fire) begin
      state      <= state_next;
      gap_timer  <= gap_timer_next;
      byte_count <= byte_count_next;
      overflowed <= overflowed_next;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (ev_fire) begin
      res_valid <= hit;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  // Result payload, loaded only when a new result is produced.
  always_ff @(posedge clk) begin
    if (ev_fire && hit) begin
      res.out_kind  <= hit_kind;
      res.out_byte  <= hit_byte;
      res.out_count <= hit_count;
      res.overflow  <= hit_ovf;
      res.fsm_now   <= state_next;
    end
  end

`ifndef SYNTHESIS
  // A character in ready opens a frame with a count of one.
  a_frame_open: assert property (@(posedge clk) disable iff (rst)
    ev_fire && state == ST_READY && ev.func == EV_CHAR
    |=> state == ST_RECEPTION && byte_count == 9'd1 && !overflowed)
    else $error("frame did not open on first character");

  // The byte count never passes the frame limit.
  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    byte_count <= FrameMax)
    else $error("byte count beyond frame limit");

  // Overflow is only raised while receiving.
  a_ovf_source: assert property (@(posedge clk) disable iff (rst)
    $rose(overflowed) |-> $past(state) == ST_RECEPTION)
    else $error("overflow raised outside reception");

  // Frame byte and transmit results never carry the overflow flag.
  a_ovf_kind: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.out_kind == K_BYTE || res.out_kind == K_TX) |-> !res.overflow)
    else $error("overflow flag on byte or transmit result");

  // A release result always lands the controller in ready.
  a_release_ready: assert property (@(posedge clk) disable iff (rst)
    ev_fire && hit && hit_kind == K_RELEASE |=> state == ST_READY)
    else $error("release did not return to ready");
`endif

endmodule

// ----- bench/mbrtu_frame_checker.sv -----
// Checker for the Modbus RTU frame timing controller: tracks the link state and compares results.
module mbrtu_frame_checker
  import mbrtu_pkg::*;
#(
  parameter int FRAME_MAX = FRAME_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        ev_valid,
  input  logic        ev_ready,
  input  ev_item_t    ev,
  input  logic        res_valid,
  input  logic        res_ready,
  input  res_item_t   res,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata,
  output int          mismatches,
  output int          pending
);

  // Shadow copy of the controller registers and state.
  state_t      link_state;
  logic [15:0] frame_gap;
  logic [15:0] char_gap;
  logic [15:0] silence;
  logic [8:0]  frame_len;
  logic        frame_ovf;

  // Results still owed by the controller, oldest first.
  res_item_t   owed_results[$];
  bit          has_result;
  res_item_t   predicted;

  // Back to the initial wait with a full silence period.
  task restart_wait;
    begin
      link_state = ST_INITIAL;
      silence = frame_gap;
    end
  endtask

  // One timer tick; returns 1 when the silence period runs out on this tick.
  function bit tick_silence();
    begin
      if (silence <= 16'd1) begin
        silence = 16'd0;
        return 1'b1;
      end
      silence = silence - 16'd1;
      return 1'b0;
    end
  endfunction

  // Advance the link state by one item and work out the result it causes, if any.
  task apply_event(input ev_item_t e, output bit hit, output res_item_t r);
    begin
      hit = 1'b0;
      r = '0;
      case (link_state)
        ST_READY: begin
          if (e.func == EV_CHAR) begin
            link_state = ST_RECEPTION;
            silence = frame_gap;
            frame_ovf = 1'b0;
            frame_len = 9'd1;
            hit = 1'b1;
            r.out_kind = K_BYTE;
            r.out_byte = e.rx_byte;
            r.out_count = 9'd0;
          end else if (e.func == EV_TXREQ) begin
            // An empty request is dropped; a long one passes through as is.
            if (e.tx_length != 9'd0) begin
              link_state = ST_EMISSION;
              hit = 1'b1;
              r.out_kind = K_TX;
              r.out_count = e.tx_length;
            end
          end else if (e.func == EV_TXDONE) begin
            restart_wait();
          end
        end
        ST_RECEPTION: begin
          if (e.func == EV_CHAR) begin
            // Characters past the frame limit are dropped but still reload the timer.
            if (frame_len < FRAME_MAX) begin
              hit = 1'b1;
              r.out_kind = K_BYTE;
              r.out_byte = e.rx_byte;
              r.out_count = frame_len;
              frame_len = frame_len + 9'd1;
            end else begin
              frame_ovf = 1'b1;
            end
            silence = frame_gap;
          end else if (e.func == EV_TICK) begin
            if (tick_silence()) begin
              silence = (frame_gap > char_gap) ? frame_gap - char_gap : 16'd0;
              link_state = ST_PROCESSING;
              hit = 1'b1;
              r.out_kind = K_END;
              r.out_count = frame_len;
              r.overflow = frame_ovf;
            end
          end else begin
            restart_wait();
          end
        end
        ST_PROCESSING: begin
          if (e.func == EV_TICK) begin
            if (tick_silence()) begin
              link_state = ST_READY;
              hit = 1'b1;
              r.out_kind = K_RELEASE;
              r.out_count = frame_len;
              r.overflow = frame_ovf;
            end
          end else begin
            restart_wait();
          end
        end
        ST_EMISSION: begin
          if (e.func == EV_TXDONE) restart_wait();
        end
        default: begin
          if (e.func == EV_TICK) begin
            if (tick_silence()) link_state = ST_READY;
          end else begin
            restart_wait();
          end
        end
      endcase
      if (hit) r.fsm_now = link_state;
    end
  endtask

  // Compare one result with the oldest one owed.
  task check_result(input res_item_t got);
    res_item_t want;
    begin
      if (owed_results.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: kind %0d byte %02h count %0d ovf %0b state %0d",
                   got.out_kind, got.out_byte, got.out_count, got.overflow, got.fsm_now);
        mismatches = mismatches + 1;
      end else begin
        want = owed_results.pop_front();
        if (got.out_kind !== want.out_kind || got.out_byte !== want.out_byte ||
            got.out_count !== want.out_count || got.overflow !== want.overflow ||
            got.fsm_now !== want.fsm_now) begin
          if (mismatches < 10)
            $display("mismatch: expected kind %0d byte %02h count %0d ovf %0b state %0d, %s",
                     want.out_kind, want.out_byte, want.out_count, want.overflow,
                     want.fsm_now,
                     $sformatf("got kind %0d byte %02h count %0d ovf %0b state %0d",
                               got.out_kind, got.out_byte, got.out_count, got.overflow,
                               got.fsm_now));
          mismatches = mismatches + 1;
        end
      end
    end
  endtask

  // Watch the configuration port and both channels at every rising edge.
  always @(posedge clk) begin
    if (rst) begin
      link_state = ST_INITIAL;
      frame_gap = FRAME_GAP_RST;
      char_gap = CHAR_GAP_RST;
      silence = FRAME_GAP_RST;
      frame_len = 9'd0;
      frame_ovf = 1'b0;
      owed_results.delete();
      mismatches = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_FRAME_GAP) frame_gap = cfg_wdata;
        else char_gap = cfg_wdata;
      end
      if (res_valid && res_ready) check_result(res);
      if (ev_valid && ev_ready) begin
        apply_event(ev, has_result, predicted);
        if (has_result) owed_results.push_back(predicted);
      end
    end
    pending <= owed_results.size();
  end

endmodule

// ----- bench/tb_modbus_rtu_frame_timing_fsm_top.sv -----
// Testbench top for the Modbus RTU frame timing controller: clock, reset, stimulus and verdict.
module tb_modbus_rtu_frame_timing_fsm_top;
  import mbrtu_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int RANDOM_ITEMS = 600;

  logic        clk = 1'b0;
  logic        rst;
  logic        ev_valid;
  logic        ev_ready;
  ev_item_t    ev;
  logic        res_valid;
  logic        res_ready = 1'b0;
  res_item_t   res;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_wdata;

  int          mismatches;
  int          pending;
  int          items_sent;
  bit          calm;
  logic [15:0] gap_now;
  logic [15:0] cgap_now;

  always #6 clk = ~clk;

  modbus_rtu_frame_timing_fsm_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .ev_valid  (ev_valid),
    .ev_ready  (ev_ready),
    .ev        (ev),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  mbrtu_frame_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .ev_valid   (ev_valid),
    .ev_ready   (ev_ready),
    .ev         (ev),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // Result side: stall about a quarter of the cycles, except during the calm stretch.
  always @(posedge clk) begin
    if (rst) res_ready <= 1'b0;
    else res_ready <= calm || ($urandom_range(99) >= 24);
  end

  // Hand one item to the controller, with an occasional idle gap before it.
  // An idle gap of random length before about one item in six keeps the sender
  // idle in roughly a quarter of the cycles.
  task send_event(input event_t f, input logic [7:0] b, input logic [8:0] len);
    begin
      if (!calm && $urandom_range(99) < 16) begin
        ev_valid <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
      ev_valid <= 1'b1;
      ev <= '{f, b, len};
      @(posedge clk);
      while (!ev_ready) @(posedge clk);
      items_sent++;
    end
  endtask

  task send_tick;
    send_event(EV_TICK, 8'($urandom), 9'($urandom));
  endtask

  task send_ticks(input int n);
    repeat (n) send_tick();
  endtask

  task send_char(input logic [7:0] b);
    send_event(EV_CHAR, b, 9'($urandom));
  endtask

  task send_any;
    send_event(event_t'($urandom_range(3)), 8'($urandom), 9'($urandom_range(0, 511)));
  endtask

  // Hold the sender until every owed result is in and the controller has settled.
  task settle;
    begin
      ev_valid <= 1'b0;
      @(negedge clk);
      while (pending != 0) @(negedge clk);
      repeat (3) @(posedge clk);
    end
  endtask

  // Write both gap registers.
  task set_gaps(input logic [15:0] fg, input logic [15:0] cg);
    begin
      cfg_we <= 1'b1;
      cfg_index <= REG_FRAME_GAP;
      cfg_wdata <= fg;
      @(posedge clk);
      cfg_index <= REG_CHAR_GAP;
      cfg_wdata <= cg;
      @(posedge clk);
      cfg_we <= 1'b0;
      gap_now = fg;
      cgap_now = cg;
    end
  endtask

  // Now and then slip a random item into an otherwise well-formed exchange.
  task maybe_noise;
    if ($urandom_range(99) < 3) send_any();
  endtask

  // One full exchange: initial wait, a received frame, processing, a reply, emission.
  task frame_exchange(input bit long_frame);
    int nbytes;
    begin
      send_event(EV_TXDONE, 8'($urandom), 9'($urandom));
      send_ticks(int'(gap_now));
      if ($urandom_range(3) == 0) send_tick();
      nbytes = long_frame ? $urandom_range(257, 270) : $urandom_range(1, 12);
      for (int i = 0; i < nbytes; i++) begin
        maybe_noise();
        if (!long_frame) send_ticks(int'($urandom_range(0, gap_now - 1)));
        send_char(8'($urandom));
      end
      send_ticks(int'(gap_now));
      maybe_noise();
      send_ticks((gap_now > cgap_now) ? int'(gap_now - cgap_now) : 1);
      if ($urandom_range(3) == 0) send_event(EV_TXREQ, 8'($urandom), 9'd0);
      send_event(EV_TXREQ, 8'($urandom), 9'($urandom_range(1, 511)));
      repeat ($urandom_range(0, 2))
        send_event(event_t'($urandom_range(EV_CHAR, EV_TXREQ)), 8'($urandom),
                   9'($urandom));
    end
  endtask

  // Stimulus.
  initial begin
    int target;
    int round;
    rst = 1'b1;
    ev_valid = 1'b0;
    ev = '0;
    cfg_we = 1'b0;
    cfg_index = REG_FRAME_GAP;
    cfg_wdata = 16'd0;
    calm = 1'b0;
    items_sent = 0;
    gap_now = FRAME_GAP_RST;
    cgap_now = CHAR_GAP_RST;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Initial wait at reset settings: a character reloads, a request restarts.
    send_event(EV_CHAR, 8'h00, 9'h1FF);
    send_event(EV_TXREQ, 8'hFF, 9'd511);
    send_tick();
    settle();
    set_gaps(16'd1, 16'd0);

    // Shortest gaps: walk every state and every event kind.
    send_event(EV_TXDONE, 8'hFF, 9'd0);
    send_tick();
    send_tick();
    send_event(EV_TXREQ, 8'h00, 9'd0);
    send_char(8'hFF);
    send_char(8'h00);
    send_tick();
    send_tick();
    send_event(EV_TXREQ, 8'h00, 9'd256);
    send_tick();
    send_char(8'h3C);
    send_event(EV_TXREQ, 8'h00, 9'd5);
    send_event(EV_TXDONE, 8'h00, 9'd0);
    send_tick();
    send_event(EV_TXDONE, 8'h00, 9'd0);
    send_tick();
    send_event(EV_TXREQ, 8'h00, 9'd511);
    send_event(EV_TXDONE, 8'h00, 9'd0);
    send_tick();
    send_char(8'h5A);
    send_event(EV_TXDONE, 8'h00, 9'd0);
    send_tick();
    send_char(8'hA5);
    send_tick();
    send_char(8'h11);
    send_tick();
    send_char(8'h22);
    send_tick();
    send_event(EV_TXREQ, 8'h00, 9'd1);
    send_tick();

    // Widest gaps: the frame never ends, then the processing wait collapses to zero.
    settle();
    set_gaps(16'hFFFF, 16'hFFFF);
    send_char(8'h80);
    send_ticks(3);
    send_char(8'h7F);
    settle();
    set_gaps(16'd2, 16'hFFFF);
    send_char(8'h01);
    send_ticks(3);
    settle();
    set_gaps(16'd3, 16'd1);

    // Random exchanges, mostly well formed, with gap settings changed between them.
    target = items_sent + RANDOM_ITEMS;
    round = 0;
    while (items_sent < target) begin
      if (round % 8 == 7) begin
        settle();
        case ($urandom_range(2))
          0: set_gaps(16'($urandom_range(1, 8)), 16'd0);
          1: set_gaps(16'($urandom_range(1, 8)), 16'hFFFF);
          default: set_gaps(16'($urandom_range(1, 8)), 16'($urandom_range(0, 10)));
        endcase
      end
      calm = (round >= 10 && round < 16);
      if (round == 4) frame_exchange(1'b1);
      else if ($urandom_range(99) < 12) repeat (10) send_any();
      else frame_exchange(1'b0);
      round++;
    end
    calm = 1'b0;

    settle();
    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  // Watchdog.
  initial begin
    #(12 * LIMIT_CYCLES);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
